// File: design/tfs_pkg.sv
package tfs_pkg;

    localparam int FREQ_W = 16;
    localparam int VOL_W  = 8;
    localparam int DUR_W  = 16;
    localparam int CNT_W  = 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_F,
        ST_DIV_V,
        ST_EMIT
    } tfs_state_t;

endpackage

// File: design/tone_frequency_slide_generator_top.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+------------------------------------------------
// request  | s_valid / s_ready  | s_audio_ready, s_start_freq, s_end_freq,
//          |                    | s_segment_count, s_segment_duration,
//          |                    | s_start_volume, s_end_volume
// command  | m_valid / m_ready  | m_tone_freq, m_tone_duration, m_tone_volume,
//          |                    | m_last_segment
//
// One restoring divider, one quotient bit per cycle, is shared by the
// frequency and the volume of each segment; each segment runs the
// frequency division, then the volume division, then the emit step.
// s_ready is high only between runs; a request that is ignored (audio not
// ready, zero count) is accepted but starts no run. The command register
// holds a result while m_ready is low, and the sequencer waits in its emit
// step until the register frees up. Reset (aresetn low, synchronous)
// returns to idle and drops any pending command.
module tone_frequency_slide_generator_top
    import tfs_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_audio_ready,
    input  logic [FREQ_W-1:0] s_start_freq,
    input  logic [FREQ_W-1:0] s_end_freq,
    input  logic [CNT_W-1:0]  s_segment_count,
    input  logic [DUR_W-1:0]  s_segment_duration,
    input  logic [VOL_W-1:0]  s_start_volume,
    input  logic [VOL_W-1:0]  s_end_volume,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [FREQ_W-1:0] m_tone_freq,
    output logic [DUR_W-1:0]  m_tone_duration,
    output logic [VOL_W-1:0]  m_tone_volume,
    output logic              m_last_segment
);

    // segment index / count width; products |diff| * i fit in PF_W / PV_W
    localparam int NW   = $clog2(MAX_SEGMENTS + 1);
    localparam int PF_W = FREQ_W + NW;
    localparam int PV_W = VOL_W + NW;
    localparam int SW   = $clog2(PF_W);

    tfs_state_t state_reg, state_next;

    // request context
    logic [NW-1:0]     n_reg, n_next;
    logic [NW-1:0]     idx_reg, idx_next;
    logic [FREQ_W-1:0] sf_reg, sf_next;
    logic [VOL_W-1:0]  sv_reg, sv_next;
    logic [DUR_W-1:0]  dur_reg, dur_next;
    logic [FREQ_W-1:0] df_mag_reg, df_mag_next;
    logic              df_neg_reg, df_neg_next;
    logic [VOL_W-1:0]  dv_mag_reg, dv_mag_next;
    logic              dv_neg_reg, dv_neg_next;

    // running products |diff| * i, built by repeated addition
    logic [PF_W-1:0]   accf_reg, accf_next;
    logic [PV_W-1:0]   accv_reg, accv_next;

    // shared divider: dividend shifts out at the top, quotient enters at the bottom
    logic [PF_W-1:0]   dvd_reg, dvd_next;
    logic [NW-1:0]     rem_reg, rem_next;
    logic [SW-1:0]     step_reg, step_next;
    logic [FREQ_W-1:0] qf_reg, qf_next;

    // command register
    logic              m_valid_reg, m_valid_next;
    logic [FREQ_W-1:0] m_freq_reg, m_freq_next;
    logic [DUR_W-1:0]  m_dur_reg, m_dur_next;
    logic [VOL_W-1:0]  m_vol_reg, m_vol_next;
    logic              m_last_reg, m_last_next;

    // control
    logic              accept;
    logic              start_run;
    logic              div_done;
    logic              load_out;
    logic              is_last;

    // divider step
    logic [NW:0]       rem_sh;
    logic [NW:0]       rem_sub;
    logic              q_bit;
    logic [PF_W-1:0]   dvd_step;
    logic [NW-1:0]     rem_step;

    // request decode
    logic [NW-1:0]     cnt_sat;
    logic [PF_W-1:0]   accf_inc;
    logic [PV_W-1:0]   accv_inc;
    logic [VOL_W-1:0]  qv;

    // -------------------------------------------------------------------
    // Output / control decode
    // -------------------------------------------------------------------
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        accept    = s_valid && s_ready;
        start_run = accept && s_audio_ready && (s_segment_count != '0);
        div_done  = (step_reg == '0);
        load_out  = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
        is_last   = (idx_reg == n_reg - NW'(1));
    end

    assign m_valid         = m_valid_reg;
    assign m_tone_freq     = m_freq_reg;
    assign m_tone_duration = m_dur_reg;
    assign m_tone_volume   = m_vol_reg;
    assign m_last_segment  = m_last_reg;

    // -------------------------------------------------------------------
    // Next state
    // -------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start_run) state_next = ST_DIV_F;
            end
            ST_DIV_F: begin
                if (div_done) state_next = ST_DIV_V;
            end
            ST_DIV_V: begin
                if (div_done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (load_out) state_next = is_last ? ST_IDLE : ST_DIV_F;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // -------------------------------------------------------------------
    // Datapath
    // -------------------------------------------------------------------
    always_comb begin
        // count saturates to MAX_SEGMENTS; it is also the divisor
        if (s_segment_count > CNT_W'(MAX_SEGMENTS)) begin
            cnt_sat = NW'(MAX_SEGMENTS);
        end else begin
            cnt_sat = s_segment_count[NW-1:0];
        end

        rem_sh   = {rem_reg, dvd_reg[PF_W-1]};
        rem_sub  = rem_sh - {1'b0, n_reg};
        q_bit    = (rem_sh >= {1'b0, n_reg});
        rem_step = q_bit ? rem_sub[NW-1:0] : rem_sh[NW-1:0];
        dvd_step = {dvd_reg[PF_W-2:0], q_bit};

        accf_inc = accf_reg + PF_W'(df_mag_reg);
        accv_inc = accv_reg + PV_W'(dv_mag_reg);
        qv       = dvd_reg[VOL_W-1:0];

        n_next       = n_reg;
        idx_next     = idx_reg;
        sf_next      = sf_reg;
        sv_next      = sv_reg;
        dur_next     = dur_reg;
        df_mag_next  = df_mag_reg;
        df_neg_next  = df_neg_reg;
        dv_mag_next  = dv_mag_reg;
        dv_neg_next  = dv_neg_reg;
        accf_next    = accf_reg;
        accv_next    = accv_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        qf_next      = qf_reg;
        m_freq_next  = m_freq_reg;
        m_dur_next   = m_dur_reg;
        m_vol_next   = m_vol_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    n_next   = cnt_sat;
                    idx_next = '0;
                    sf_next  = s_start_freq;
                    sv_next  = s_start_volume;
                    dur_next = s_segment_duration;
                    // sign and magnitude of end - start
                    df_neg_next = (s_end_freq < s_start_freq);
                    df_mag_next = (s_end_freq < s_start_freq) ?
                                  s_start_freq - s_end_freq : s_end_freq - s_start_freq;
                    dv_neg_next = (s_end_volume < s_start_volume);
                    dv_mag_next = (s_end_volume < s_start_volume) ?
                                  s_start_volume - s_end_volume :
                                  s_end_volume - s_start_volume;
                    accf_next = '0;
                    accv_next = '0;
                    dvd_next  = '0;
                    rem_next  = '0;
                    step_next = SW'(PF_W - 1);
                end
            end
            ST_DIV_F: begin
                dvd_next  = dvd_step;
                rem_next  = rem_step;
                step_next = step_reg - SW'(1);
                if (div_done) begin
                    qf_next = dvd_step[FREQ_W-1:0];
                    // volume product left-aligned, runs PV_W steps
                    dvd_next  = PF_W'(accv_reg) << (PF_W - PV_W);
                    rem_next  = '0;
                    step_next = SW'(PV_W - 1);
                end
            end
            ST_DIV_V: begin
                dvd_next  = dvd_step;
                rem_next  = rem_step;
                step_next = step_reg - SW'(1);
            end
            ST_EMIT: begin
                if (load_out) begin
                    m_valid_next = 1'b1;
                    m_freq_next  = df_neg_reg ? sf_reg - qf_reg : sf_reg + qf_reg;
                    m_vol_next   = dv_neg_reg ? sv_reg - qv : sv_reg + qv;
                    m_dur_next   = dur_reg;
                    m_last_next  = is_last;
                    // next segment
                    idx_next  = idx_reg + NW'(1);
                    accf_next = accf_inc;
                    accv_next = accv_inc;
                    dvd_next  = accf_inc;
                    rem_next  = '0;
                    step_next = SW'(PF_W - 1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        idx_reg    <= idx_next;
        sf_reg     <= sf_next;
        sv_reg     <= sv_next;
        dur_reg    <= dur_next;
        df_mag_reg <= df_mag_next;
        df_neg_reg <= df_neg_next;
        dv_mag_reg <= dv_mag_next;
        dv_neg_reg <= dv_neg_next;
        accf_reg   <= accf_next;
        accv_reg   <= accv_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        qf_reg     <= qf_next;
        m_freq_reg <= m_freq_next;
        m_dur_reg  <= m_dur_next;
        m_vol_reg  <= m_vol_next;
        m_last_reg <= m_last_next;
    end

`ifndef SYNTHESIS
    // divider remainder stays below the divisor
    a_rem_lt_n: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_F || state_reg == ST_DIV_V) |-> (rem_reg < n_reg))
        else $error("divider remainder not below segment count");

    // segment index stays inside the run
    a_idx_lt_n: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (idx_reg < n_reg))
        else $error("segment index past segment count");

    // the last command ends the run
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && is_last) |=> (s_ready && m_last_reg))
        else $error("run did not end after last segment");

    // a command appears only from the emit step
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("command raised outside emit step");
`endif

endmodule
